@@ hw/rtl/rc4_stream_cipher_top_assert.svh @@
// ---------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Shorthand for clocked implication checks used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_TOP_ASSERT_SVH
`define RC4_STREAM_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RC4_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc4 assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RC4_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc4 assertion failed");

`endif

@@ hw/rtl/rc4_pkg.sv @@
// ---------------------------------------------------------------------------
// RC4 package
// Shared widths, register codes, sequencer states and key helpers.
// ---------------------------------------------------------------------------
package rc4_pkg;

  localparam int MAX_KEY_BYTES = 32;
  localparam int MIN_KEY_BYTES = 5;
  localparam int KEY_REG_BYTES = 32;
  localparam int KEY_BITS      = 8 * KEY_REG_BYTES;
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int KEY_LEN_W     = $clog2(MAX_KEY_BYTES + 1);

  localparam int SBOX_AW       = 8;
  localparam int BYTE_W        = 8;
  localparam int DROP_W        = 12;
  localparam int KEY_BYTES_W   = 6;
  localparam int APB_DW        = 64;
  localparam int APB_AW        = 6;
  localparam int REG_IDX_W     = 3;

  localparam logic [KEY_BYTES_W-1:0] KEY_BYTES_RESET = 6'd16;
  localparam logic [DROP_W-1:0]      DROP_RESET      = 12'd3072;

  localparam logic [REG_IDX_W-1:0] REG_KEY0      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY1      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY2      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY3      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_BYTES = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DROP      = 3'd5;

  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef logic [KEY_LEN_W-1:0] key_len_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [KEY_BYTES_W-1:0] key_bytes;
    logic [DROP_W-1:0]      drop_count;
  } rc4_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KSA_RD_I,
    ST_KSA_RD_J,
    ST_KSA_WR_I,
    ST_KSA_WR_J,
    ST_PRG_RD_I,
    ST_PRG_RD_J,
    ST_PRG_RD_T,
    ST_PRG_WR_I,
    ST_PRG_WR_J,
    ST_HOLD
  } rc4_state_t;

  // Key byte k of the register file; bytes past the registers read as zero.
  function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_BITS-1:0] key,
                                                 input key_idx_t idx);
    if (int'(idx) >= KEY_REG_BYTES) begin
      key_byte = '0;
    end else begin
      key_byte = key[8*idx +: 8];
    end
  endfunction

  // Saturate the programmed key length into the legal range.
  function automatic key_len_t clamp_len(input logic [KEY_BYTES_W-1:0] kb);
    if (int'(kb) < MIN_KEY_BYTES) begin
      clamp_len = key_len_t'(MIN_KEY_BYTES);
    end else if (int'(kb) > MAX_KEY_BYTES) begin
      clamp_len = key_len_t'(MAX_KEY_BYTES);
    end else begin
      clamp_len = key_len_t'(kb);
    end
  endfunction

endpackage

@@ hw/rtl/rc4_stream_cipher_top.sv @@
// A keyed byte runs PRG_RD_I, RD_J, RD_T, WR_I and WR_J before its registered output.
// Each byte makes 3 reads and 2 writes on the single S-box port, and the next waits for it.
// A rekey first runs the fill, the key schedule and the drop of drop_count bytes.
// Reset is synchronous and active high; it clears i, j, the keyed flag and the registers.
// S-box contents stay unknown after reset; the first byte always runs the key schedule.
// ---------------------------------------------------------------------------
// RC4 stream cipher top level
// RC4-drop byte cipher with an APB register file and stream ports.
// ---------------------------------------------------------------------------
`include "rc4_stream_cipher_top_assert.svh"

module rc4_stream_cipher_top (
  input  logic                            clk,
  input  logic                            rst,
  // slave side: one byte per beat
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_in
  input  logic                            s_tuser,   // [0] rekey
  // master side: one result per beat
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] data_out
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rc4_pkg::APB_AW-1:0]      paddr,
  input  logic [rc4_pkg::APB_DW-1:0]      pwdata,
  output logic [rc4_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  rc4_pkg::rc4_cfg_t               cfg;
  logic                            sbox_we;
  logic [rc4_pkg::SBOX_AW-1:0]     sbox_addr;
  logic [rc4_pkg::BYTE_W-1:0]      sbox_wdata;
  logic [rc4_pkg::BYTE_W-1:0]      sbox_rdata;
  logic                            keyed;

  // Key, key length and drop count; read by the core during the next rekey.
  rc4_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // 256-entry permutation; every access of the cipher goes through this one port.
  rc4_sbox_ram #(
    .ADDR_W (rc4_pkg::SBOX_AW),
    .DATA_W (rc4_pkg::BYTE_W)
  ) u_sbox (
    .clk   (clk),
    .we    (sbox_we),
    .addr  (sbox_addr),
    .wdata (sbox_wdata),
    .rdata (sbox_rdata)
  );

  // Sequencer: fill, key schedule, drop, then one keystream byte per beat.
  // The output register lets the next beat in while a result waits.
  rc4_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .sbox_we    (sbox_we),
    .sbox_addr  (sbox_addr),
    .sbox_wdata (sbox_wdata),
    .sbox_rdata (sbox_rdata),
    .keyed      (keyed)
  );

  // Drop ready once a beat is taken.
  `RC4_ASSERT_NXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  // Never write the S-box while waiting for input.
  `RC4_ASSERT_IMP(a_no_write_idle, clk, rst, s_tready, !sbox_we)
  // A result only appears after a full key schedule.
  `RC4_ASSERT_IMP(a_result_keyed, clk, rst, $rose(m_tvalid), keyed)

endmodule

@@ hw/rtl/rc4_sbox_ram.sv @@
// ---------------------------------------------------------------------------
// RC4 S-box RAM
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module rc4_sbox_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/rc4_regs.sv @@
// ---------------------------------------------------------------------------
// RC4 configuration registers
// APB register file for key words, key length and drop count.
// ---------------------------------------------------------------------------
module rc4_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rc4_pkg::APB_AW-1:0]          paddr,
  input  logic [rc4_pkg::APB_DW-1:0]          pwdata,
  output logic [rc4_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  output rc4_pkg::rc4_cfg_t                   cfg
);

  logic [rc4_pkg::APB_DW-1:0]      key_word [4];
  logic [rc4_pkg::KEY_BYTES_W-1:0] key_bytes;
  logic [rc4_pkg::DROP_W-1:0]      drop_count;
  logic [rc4_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rc4_pkg::APB_AW-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word[0] <= '0;
      key_word[1] <= '0;
      key_word[2] <= '0;
      key_word[3] <= '0;
      key_bytes   <= rc4_pkg::KEY_BYTES_RESET;
      drop_count  <= rc4_pkg::DROP_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        rc4_pkg::REG_KEY0:      key_word[0] <= pwdata;
        rc4_pkg::REG_KEY1:      key_word[1] <= pwdata;
        rc4_pkg::REG_KEY2:      key_word[2] <= pwdata;
        rc4_pkg::REG_KEY3:      key_word[3] <= pwdata;
        rc4_pkg::REG_KEY_BYTES: key_bytes   <= pwdata[rc4_pkg::KEY_BYTES_W-1:0];
        rc4_pkg::REG_DROP:      drop_count  <= pwdata[rc4_pkg::DROP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rc4_pkg::REG_KEY0:      prdata = key_word[0];
      rc4_pkg::REG_KEY1:      prdata = key_word[1];
      rc4_pkg::REG_KEY2:      prdata = key_word[2];
      rc4_pkg::REG_KEY3:      prdata = key_word[3];
      rc4_pkg::REG_KEY_BYTES: prdata = {{(rc4_pkg::APB_DW-rc4_pkg::KEY_BYTES_W){1'b0}},
                                        key_bytes};
      rc4_pkg::REG_DROP:      prdata = {{(rc4_pkg::APB_DW-rc4_pkg::DROP_W){1'b0}},
                                        drop_count};
      default:                prdata = '0;
    endcase
  end

  assign cfg.key        = {key_word[3], key_word[2], key_word[1], key_word[0]};
  assign cfg.key_bytes  = key_bytes;
  assign cfg.drop_count = drop_count;

endmodule

@@ hw/rtl/rc4_core.sv @@
// ---------------------------------------------------------------------------
// RC4 sequencer
// Drives the S-box port through fill, key schedule, drop and byte output.
// ---------------------------------------------------------------------------
module rc4_core (
  input  logic                            clk,
  input  logic                            rst,
  input  rc4_pkg::rc4_cfg_t               cfg,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rc4_pkg::BYTE_W-1:0]      s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rc4_pkg::BYTE_W-1:0]      m_tdata,
  output logic                            sbox_we,
  output logic [rc4_pkg::SBOX_AW-1:0]     sbox_addr,
  output logic [rc4_pkg::BYTE_W-1:0]      sbox_wdata,
  input  logic [rc4_pkg::BYTE_W-1:0]      sbox_rdata,
  output logic                            keyed
);

  rc4_pkg::rc4_state_t         state;
  rc4_pkg::rc4_state_t         state_next;
  logic [7:0]                  index_i;
  logic [7:0]                  index_j;
  logic [7:0]                  si;
  logic [7:0]                  sj;
  logic [7:0]                  t_addr;
  logic [7:0]                  data_q;
  logic [7:0]                  res;
  rc4_pkg::key_idx_t           kidx;
  rc4_pkg::key_len_t           len;
  logic [rc4_pkg::DROP_W-1:0]  drop_left;
  logic                        dropping;
  logic                        out_free;
  logic                        load_out;
  logic [7:0]                  ksa_j;
  logic [7:0]                  prg_j;
  logic [7:0]                  ks;

  assign len      = rc4_pkg::clamp_len(cfg.key_bytes);
  assign dropping = (drop_left != '0);
  assign out_free = !m_tvalid || m_tready;
  assign ksa_j    = index_j + sbox_rdata + rc4_pkg::key_byte(cfg.key, kidx);
  assign prg_j    = index_j + sbox_rdata;

  // Forward the swapped values when the output index hits i or j.
  always_comb begin
    if (t_addr == index_i) begin
      ks = sj;
    end else if (t_addr == index_j) begin
      ks = si;
    end else begin
      ks = sbox_rdata;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rc4_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser || !keyed) ? rc4_pkg::ST_FILL : rc4_pkg::ST_PRG_RD_I;
        end
      end
      rc4_pkg::ST_FILL: begin
        if (index_i == 8'hFF) begin
          state_next = rc4_pkg::ST_KSA_RD_I;
        end
      end
      rc4_pkg::ST_KSA_RD_I: state_next = rc4_pkg::ST_KSA_RD_J;
      rc4_pkg::ST_KSA_RD_J: state_next = rc4_pkg::ST_KSA_WR_I;
      rc4_pkg::ST_KSA_WR_I: state_next = rc4_pkg::ST_KSA_WR_J;
      rc4_pkg::ST_KSA_WR_J: begin
        state_next = (index_i == 8'hFF) ? rc4_pkg::ST_PRG_RD_I : rc4_pkg::ST_KSA_RD_I;
      end
      rc4_pkg::ST_PRG_RD_I: state_next = rc4_pkg::ST_PRG_RD_J;
      rc4_pkg::ST_PRG_RD_J: state_next = rc4_pkg::ST_PRG_RD_T;
      rc4_pkg::ST_PRG_RD_T: begin
        state_next = dropping ? rc4_pkg::ST_PRG_WR_J : rc4_pkg::ST_PRG_WR_I;
      end
      rc4_pkg::ST_PRG_WR_I: state_next = rc4_pkg::ST_PRG_WR_J;
      rc4_pkg::ST_PRG_WR_J: begin
        if (dropping) begin
          state_next = rc4_pkg::ST_PRG_RD_I;
        end else begin
          state_next = out_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_HOLD;
        end
      end
      rc4_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = rc4_pkg::ST_IDLE;
        end
      end
      default: state_next = rc4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    sbox_we    = 1'b0;
    sbox_addr  = index_i;
    sbox_wdata = '0;
    load_out   = 1'b0;
    case (state)
      rc4_pkg::ST_IDLE: s_tready = 1'b1;
      rc4_pkg::ST_FILL: begin
        sbox_we    = 1'b1;
        sbox_wdata = index_i;
      end
      rc4_pkg::ST_KSA_RD_I: sbox_addr = index_i;
      rc4_pkg::ST_KSA_RD_J: sbox_addr = ksa_j;
      rc4_pkg::ST_KSA_WR_I: begin
        sbox_we    = 1'b1;
        sbox_wdata = sbox_rdata;
      end
      rc4_pkg::ST_KSA_WR_J: begin
        sbox_we    = 1'b1;
        sbox_addr  = index_j;
        sbox_wdata = si;
      end
      rc4_pkg::ST_PRG_RD_I: sbox_addr = index_i + 8'd1;
      rc4_pkg::ST_PRG_RD_J: sbox_addr = prg_j;
      rc4_pkg::ST_PRG_RD_T: begin
        if (dropping) begin
          sbox_we    = 1'b1;
          sbox_wdata = sbox_rdata;
        end else begin
          sbox_addr = si + sbox_rdata;
        end
      end
      rc4_pkg::ST_PRG_WR_I: begin
        sbox_we    = 1'b1;
        sbox_wdata = sj;
      end
      rc4_pkg::ST_PRG_WR_J: begin
        sbox_we    = 1'b1;
        sbox_addr  = index_j;
        sbox_wdata = si;
        load_out   = !dropping && out_free;
      end
      rc4_pkg::ST_HOLD: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rc4_pkg::ST_IDLE;
      index_i   <= '0;
      index_j   <= '0;
      kidx      <= '0;
      drop_left <= '0;
      keyed     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        rc4_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            data_q <= s_tdata;
            if (s_tuser || !keyed) begin
              index_i   <= '0;
              index_j   <= '0;
              kidx      <= '0;
              drop_left <= cfg.drop_count;
            end
          end
        end
        rc4_pkg::ST_FILL: index_i <= index_i + 8'd1;
        rc4_pkg::ST_KSA_RD_J: begin
          si      <= sbox_rdata;
          index_j <= ksa_j;
        end
        rc4_pkg::ST_KSA_WR_J: begin
          index_i <= index_i + 8'd1;
          if (rc4_pkg::key_len_t'(kidx) == len - rc4_pkg::key_len_t'(1)) begin
            kidx <= '0;
          end else begin
            kidx <= kidx + rc4_pkg::key_idx_t'(1);
          end
          // End of the schedule: restart both indices for the keystream.
          if (index_i == 8'hFF) begin
            index_j <= '0;
            keyed   <= 1'b1;
          end
        end
        rc4_pkg::ST_PRG_RD_I: index_i <= index_i + 8'd1;
        rc4_pkg::ST_PRG_RD_J: begin
          si      <= sbox_rdata;
          index_j <= prg_j;
        end
        rc4_pkg::ST_PRG_RD_T: begin
          sj     <= sbox_rdata;
          t_addr <= si + sbox_rdata;
        end
        rc4_pkg::ST_PRG_WR_I: res <= data_q ^ ks;
        rc4_pkg::ST_PRG_WR_J: begin
          if (dropping) begin
            drop_left <= drop_left - rc4_pkg::DROP_W'(1);
          end
        end
        default: ;
      endcase
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= res;
    end
  end

endmodule

@@ dv/rc4_stream_cipher_checker.sv @@
// ---------------------------------------------------------------------------
// RC4 stream cipher checker
// Watches the register port and both stream channels, keeps its own copy of
// the cipher state and compares every master-side beat with the byte it
// should carry.
// ---------------------------------------------------------------------------
module rc4_stream_cipher_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] data_in
  input  logic                       s_tuser,   // [0] rekey
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [7:0]                 m_tdata,   // [7:0] data_out
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [rc4_pkg::APB_AW-1:0] paddr,
  input  logic [rc4_pkg::APB_DW-1:0] pwdata,
  output int                         fail_count,
  output int                         pending,
  output int                         bytes_checked
);

  // register copy
  logic [63:0]                     key_reg [4];
  logic [rc4_pkg::KEY_BYTES_W-1:0] key_len_reg;
  logic [rc4_pkg::DROP_W-1:0]      drop_reg;

  // cipher state copy
  logic [7:0] sbox [256];
  logic [7:0] ptr_i;
  logic [7:0] ptr_j;
  bit         is_keyed;

  logic [7:0] cipher_expected [$];
  logic [7:0] want_byte;

  function automatic logic [7:0] keystream_byte();
    logic [7:0] swap_tmp;
    logic [7:0] out_idx;
    ptr_i          = ptr_i + 8'd1;
    ptr_j          = ptr_j + sbox[ptr_i];
    swap_tmp       = sbox[ptr_i];
    sbox[ptr_i]    = sbox[ptr_j];
    sbox[ptr_j]    = swap_tmp;
    out_idx        = sbox[ptr_i] + sbox[ptr_j];
    return sbox[out_idx];
  endfunction

  function automatic void run_key_schedule();
    int         len;
    int         k;
    logic [7:0] acc;
    logic [7:0] swap_tmp;
    len = int'(key_len_reg);
    if (len < rc4_pkg::MIN_KEY_BYTES) len = rc4_pkg::MIN_KEY_BYTES;
    if (len > rc4_pkg::MAX_KEY_BYTES) len = rc4_pkg::MAX_KEY_BYTES;
    for (int n = 0; n < 256; n++) sbox[n] = n[7:0];
    acc = 8'd0;
    for (int n = 0; n < 256; n++) begin
      k         = n % len;
      acc       = acc + sbox[n] +
                  ((k < rc4_pkg::KEY_REG_BYTES) ? key_reg[k/8][8*(k%8) +: 8] : 8'd0);
      swap_tmp  = sbox[n];
      sbox[n]   = sbox[acc];
      sbox[acc] = swap_tmp;
    end
    ptr_i = 8'd0;
    ptr_j = 8'd0;
    // discard the first drop_count keystream bytes
    for (int n = 0; n < int'(drop_reg); n++) void'(keystream_byte());
    is_keyed = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < 4; w++) key_reg[w] = '0;
      key_len_reg = rc4_pkg::KEY_BYTES_RESET;
      drop_reg    = rc4_pkg::DROP_RESET;
      ptr_i       = 8'd0;
      ptr_j       = 8'd0;
      is_keyed    = 1'b0;
      cipher_expected.delete();
      fail_count    <= 0;
      bytes_checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          rc4_pkg::REG_KEY0, rc4_pkg::REG_KEY1,
          rc4_pkg::REG_KEY2, rc4_pkg::REG_KEY3: key_reg[paddr[4:3]] = pwdata[63:0];
          rc4_pkg::REG_KEY_BYTES: key_len_reg = pwdata[rc4_pkg::KEY_BYTES_W-1:0];
          rc4_pkg::REG_DROP:      drop_reg    = pwdata[rc4_pkg::DROP_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser || !is_keyed) run_key_schedule();
        cipher_expected.push_back(s_tdata ^ keystream_byte());
      end
      if (m_tvalid && m_tready) begin
        if (cipher_expected.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected data_out beat: expected none, got %02h", $time, m_tdata);
        end else begin
          want_byte = cipher_expected.pop_front();
          if (m_tdata !== want_byte) begin
            fail_count <= fail_count + 1;
            $display("%0t: data_out mismatch: expected %02h, got %02h",
                     $time, want_byte, m_tdata);
          end
        end
        bytes_checked <= bytes_checked + 1;
      end
    end
    pending <= cipher_expected.size();
  end

endmodule

@@ dv/rc4_stream_cipher_top_tb.sv @@
// ---------------------------------------------------------------------------
// RC4 stream cipher testbench
// Programs key, key length and drop count over the register port, streams
// bytes with random gaps and back-pressure, and lets the checker compare
// every output byte against its own copy of the cipher.
// ---------------------------------------------------------------------------
module rc4_stream_cipher_top_tb;

  // indexes past the register file; writes there must be dropped
  localparam logic [rc4_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rc4_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int MAX_WAIT      = 18;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES   = 212;
  localparam int REKEY_ODDS    = 40;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [7:0]                 s_tdata = '0;  // [7:0] data_in
  logic                       s_tuser = 1'b0; // [0] rekey
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [7:0]                 m_tdata;       // [7:0] data_out
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [rc4_pkg::APB_AW-1:0] paddr = '0;
  logic [rc4_pkg::APB_DW-1:0] pwdata = '0;
  logic [rc4_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  int fail_count;
  int pending;
  int bytes_checked;

  // traffic shaping shared between the sender, the receiver and the sequence
  bit quiet_tx;
  bit quiet_rx;
  bit hold_off_req;
  int bytes_sent;
  int rekeys_sent;
  int settings_loaded;

  always #5 clk = ~clk;

  rc4_stream_cipher_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rc4_stream_cipher_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  // Write one register: setup cycle, then access cycle until pready.
  // Called at a falling edge, returns at a falling edge.
  task automatic reg_write(input logic [rc4_pkg::REG_IDX_W-1:0] idx,
                           input logic [rc4_pkg::APB_DW-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program all six registers; key_bytes and drop_count take the raw word so
  // the upper bits exercise the field masking.
  task automatic load_settings(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3,
                               input logic [63:0] len_word, input logic [63:0] drop_word);
    reg_write(rc4_pkg::REG_KEY0, k0);
    reg_write(rc4_pkg::REG_KEY1, k1);
    reg_write(rc4_pkg::REG_KEY2, k2);
    reg_write(rc4_pkg::REG_KEY3, k3);
    reg_write(rc4_pkg::REG_KEY_BYTES, len_word);
    reg_write(rc4_pkg::REG_DROP, drop_word);
    settings_loaded++;
  endtask

  // Offer one beat on the slave side after a random gap. Keep tvalid high
  // between back-to-back beats so it is never dropped and raised in one step.
  task automatic send_byte(input logic [7:0] data, input logic rekey);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= rekey;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    bytes_sent++;
    if (rekey) rekeys_sent++;
  endtask

  // Drop tvalid and hold until every predicted byte has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_stream(input int count, input bit first_rekey);
    logic [7:0] data;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom_range(0, 255));
      endcase
      send_byte(data, (n == 0) ? first_rekey : ($urandom_range(0, REKEY_ODDS - 1) == 0));
    end
  endtask

  // Receiver: draw a stall per beat, run bare stretches when quiet_rx is set,
  // and honor a long hold-off request counted here in cycles.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = quiet_rx ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Hard limit on the run: far past the slowest legal run.
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: zero key, 16 key bytes, drop 3072. The first byte keys
    // the block on its own; the third forces a second schedule.
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain();

    // All-ones key at full length with no drop.
    quiet_tx = 1'b0;
    load_settings('1, '1, '1, '1, 64'd32, 64'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    drain();

    // Key length zero saturates up to the minimum; drop at its maximum.
    // Upper bits of both words are ones and must be masked off.
    load_settings(rand64(), rand64(), rand64(), rand64(), 64'hFFFF_FFFF_FFFF_FFC0, '1);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
    drain();

    // Zero key, length 63 saturates down to 32, drop of one. Writes to the
    // unused indexes must not disturb anything.
    quiet_rx = 1'b0;
    load_settings('0, '0, '0, '0, 64'd63, 64'd1);
    reg_write(REG_SPARE_LO, rand64());
    reg_write(REG_SPARE_HI, '1);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // Shortest legal key, no drop; then change the key without rekeying so
    // the old stream must continue.
    load_settings(rand64(), rand64(), rand64(), rand64(), 64'd5, 64'd0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    drain();
    reg_write(rc4_pkg::REG_KEY0, rand64());
    send_byte(8'h7F, 1'b0);
    drain();

    // Random phases: fresh settings each time, small drop counts so the
    // schedules stay short, rare rekeys inside the stream.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet_tx = ($urandom_range(0, 3) == 0);
      quiet_rx = ($urandom_range(0, 3) == 0);
      load_settings(rand64(), rand64(), rand64(), rand64(), rand64(),
                    {52'(rand64() >> 12), 4'b0000, 8'($urandom_range(0, 255))});
      if (p == 3) begin
        // Stall the master side for a long stretch while the sender streams
        // flat out, so the block backs up and drops s_tready.
        quiet_tx     = 1'b1;
        hold_off_req = 1'b1;
      end
      if (p == 5) begin
        // Pause the sender mid-phase until every result is back.
        random_stream(PHASE_BYTES / 2, 1'b1);
        drain();
        random_stream(PHASE_BYTES - PHASE_BYTES / 2, 1'b0);
      end else begin
        random_stream(PHASE_BYTES, p[0]);
      end
      drain();
    end

    // Let any stray beat surface before the verdict.
    repeat (50) @(negedge clk);

    $display("Run covered %0d bytes with %0d explicit rekeys across %0d register settings;",
             bytes_sent, rekeys_sent, settings_loaded);
    $display("%0d output bytes were compared, including long back-pressure and idle pauses.",
             bytes_checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ rc4_stream_cipher_top.f @@
+incdir+hw/rtl
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_sbox_ram.sv
hw/rtl/rc4_regs.sv
hw/rtl/rc4_core.sv
hw/rtl/rc4_stream_cipher_top.sv
dv/rc4_stream_cipher_checker.sv
dv/rc4_stream_cipher_top_tb.sv
